>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the interval timer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SIT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define SIT_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Types, codes and constants shared by the scaled interval timer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

    localparam int TIME_BITS_DEF       = 32;
    localparam int SCALE_FRAC_BITS_DEF = 8;

    localparam int KIND_W     = 3;
    localparam int DELTA_W    = 20;
    localparam int IN_DATA_W  = 24;
    localparam int SCALE_W    = 16;
    localparam int TIME_W     = 32;
    localparam int CNT_W      = 16;
    localparam int CH_EN_W    = 4;
    localparam int NUM_CH     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_W      = 104;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 3'd0,
        KIND_START  = 3'd1,
        KIND_STOP   = 3'd2,
        KIND_RESET  = 3'd3,
        KIND_RESUME = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DURATION  = 3'd0,
        REG_LOOP_EN   = 3'd1,
        REG_SCALE     = 3'd2,
        REG_OS_TIME_A = 3'd3,
        REG_OS_TIME_B = 3'd4,
        REG_PERIOD_A  = 3'd5,
        REG_PERIOD_B  = 3'd6,
        REG_CH_EN     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [TIME_W-1:0]  duration;
        logic               loop_en;
        logic [SCALE_W-1:0] scale;
        logic [TIME_W-1:0]  os_time_a;
        logic [TIME_W-1:0]  os_time_b;
        logic [TIME_W-1:0]  period_a;
        logic [TIME_W-1:0]  period_b;
        logic [CH_EN_W-1:0] ch_en;
    } t_cfg;

    localparam t_cfg CFG_RST = '{
        duration:  32'd65536,
        loop_en:   1'b0,
        scale:     16'd256,
        os_time_a: 32'd0,
        os_time_b: 32'd0,
        period_a:  32'd0,
        period_b:  32'd0,
        ch_en:     4'd0
    };

    // Declared from the top bit down so that active lands in bit 0.
    typedef struct packed {
        logic [TIME_W-1:0] remaining;
        logic [TIME_W-1:0] elapsed;
        logic [CNT_W-1:0]  count_b;
        logic [CNT_W-1:0]  count_a;
        logic [1:0]        period_fired;
        logic [1:0]        oneshot_fired;
        logic              completed;
        logic              looped;
        logic              finished;
        logic              active;
    } t_result;

endpackage

`default_nettype wire

>>> src/sit_cfg_regs.sv
// ----------------------------------------------------------------------------
// sit_cfg_regs
// Configuration register file of the interval timer, one write per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_wr_valid,
    input  wire logic [sit_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  wire logic [sit_pkg::CFG_DATA_W-1:0]  i_wr_data,
    output sit_pkg::t_cfg                        o_cfg
);
    import sit_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else if (i_wr_valid) begin
            unique case (t_cfg_idx'(i_wr_index))
                REG_DURATION:  r_cfg.duration  <= i_wr_data[TIME_W-1:0];
                REG_LOOP_EN:   r_cfg.loop_en   <= i_wr_data[0];
                REG_SCALE:     r_cfg.scale     <= i_wr_data[SCALE_W-1:0];
                REG_OS_TIME_A: r_cfg.os_time_a <= i_wr_data[TIME_W-1:0];
                REG_OS_TIME_B: r_cfg.os_time_b <= i_wr_data[TIME_W-1:0];
                REG_PERIOD_A:  r_cfg.period_a  <= i_wr_data[TIME_W-1:0];
                REG_PERIOD_B:  r_cfg.period_b  <= i_wr_data[TIME_W-1:0];
                REG_CH_EN:     r_cfg.ch_en     <= i_wr_data[CH_EN_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> src/sit_scale.sv
// ----------------------------------------------------------------------------
// sit_scale
// Multiplies a tick delta by the fixed-point time scale and drops the
// fraction bits of the scale, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_scale #(
    parameter int SCALE_FRAC_BITS = sit_pkg::SCALE_FRAC_BITS_DEF
) (
    input  wire logic [sit_pkg::DELTA_W-1:0]  i_delta,
    input  wire logic [sit_pkg::SCALE_W-1:0]  i_scale,
    output logic [sit_pkg::DELTA_W+sit_pkg::SCALE_W-SCALE_FRAC_BITS-1:0] o_step
);
    import sit_pkg::*;

    localparam int PROD_W = DELTA_W + SCALE_W;

    logic [PROD_W-1:0] prod;

    assign prod   = PROD_W'(i_delta) * PROD_W'(i_scale);
    assign o_step = prod[PROD_W-1:SCALE_FRAC_BITS];

endmodule

`default_nettype wire

>>> src/sit_core.sv
// ----------------------------------------------------------------------------
// sit_core
// Timer state and the single-pass update for one item: time advance,
// compare channels, duration handling and the control commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_core #(
    parameter int TIME_BITS       = sit_pkg::TIME_BITS_DEF,
    parameter int SCALE_FRAC_BITS = sit_pkg::SCALE_FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire sit_pkg::t_kind              i_kind,
    input  wire logic [sit_pkg::DELTA_W-1:0] i_delta,
    input  wire sit_pkg::t_cfg               i_cfg,
    output sit_pkg::t_result                 o_res
);
    import sit_pkg::*;

    localparam int TB = TIME_BITS;
    localparam int CW = (TB > TIME_W) ? TB : TIME_W;
    localparam int SW = DELTA_W + SCALE_W - SCALE_FRAC_BITS;
    localparam int AW = ((TB > SW) ? TB : SW) + 1;
    localparam int NW = CW + 1;

    typedef logic [TB-1:0] t_time;
    typedef logic [CW-1:0] t_cmp;
    typedef logic [AW-1:0] t_acc;
    typedef logic [NW-1:0] t_nsum;

    localparam t_time TIME_MAX = '1;

    function automatic t_time clamp_period(input logic [TIME_W-1:0] p);
        t_cmp pc;
        pc = t_cmp'(p);
        return (pc > t_cmp'(TIME_MAX)) ? TIME_MAX : pc[TB-1:0];
    endfunction

    t_time            r_elapsed, n_elapsed;
    logic             r_running, n_running;
    logic             r_done,    n_done;
    logic             r_loop,    n_loop;
    logic [NUM_CH-1:0] r_os_done, n_os_done;
    t_time            r_nft [NUM_CH];
    t_time            n_nft [NUM_CH];
    logic [CNT_W-1:0] r_cnt [NUM_CH];
    logic [CNT_W-1:0] n_cnt [NUM_CH];

    logic [SW-1:0]     step;
    t_acc              acc;
    t_time             el_adv;
    t_cmp              el_cmp;
    t_cmp              dur_cmp;
    t_cmp              el_out;
    t_cmp              rem;
    logic              dur_hit;
    logic              resume_ok;
    logic              completed;
    logic [NUM_CH-1:0] os_mask;
    logic [NUM_CH-1:0] pd_mask;
    logic [NUM_CH-1:0] os_hit;
    logic [NUM_CH-1:0] pd_hit;
    logic [TIME_W-1:0] os_time [NUM_CH];
    logic [TIME_W-1:0] period  [NUM_CH];
    t_nsum             nsum    [NUM_CH];
    t_time             nft_adv [NUM_CH];
    t_time             nft_arm [NUM_CH];
    logic [CNT_W-1:0]  cnt_inc [NUM_CH];

    sit_scale #(
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_scale (
        .i_delta (i_delta),
        .i_scale (i_cfg.scale),
        .o_step  (step)
    );

    assign os_time[0] = i_cfg.os_time_a;
    assign os_time[1] = i_cfg.os_time_b;
    assign period[0]  = i_cfg.period_a;
    assign period[1]  = i_cfg.period_b;

    // Advanced time saturates at the top of the time range.
    assign acc       = t_acc'(r_elapsed) + t_acc'(step);
    assign el_adv    = (|acc[AW-1:TB]) ? TIME_MAX : acc[TB-1:0];
    assign el_cmp    = t_cmp'(el_adv);
    assign dur_cmp   = t_cmp'(i_cfg.duration);
    assign dur_hit   = el_cmp >= dur_cmp;
    assign resume_ok = t_cmp'(r_elapsed) < dur_cmp;

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            os_hit[i]  = i_cfg.ch_en[i] && !r_os_done[i] && (el_cmp >= t_cmp'(os_time[i]));
            pd_hit[i]  = i_cfg.ch_en[i+NUM_CH] && (el_cmp >= t_cmp'(r_nft[i]));
            nsum[i]    = t_nsum'(r_nft[i]) + t_nsum'(period[i]);
            nft_adv[i] = (nsum[i] > t_nsum'(TIME_MAX)) ? TIME_MAX : nsum[i][TB-1:0];
            nft_arm[i] = clamp_period(period[i]);
            cnt_inc[i] = (r_cnt[i] == CNT_MAX) ? r_cnt[i] : r_cnt[i] + CNT_W'(1);
        end
    end

    always_comb begin
        n_elapsed = r_elapsed;
        n_running = r_running;
        n_done    = r_done;
        n_loop    = r_loop;
        n_os_done = r_os_done;
        n_nft     = r_nft;
        n_cnt     = r_cnt;
        completed = 1'b0;
        os_mask   = '0;
        pd_mask   = '0;
        unique case (i_kind)
            KIND_TICK: begin
                if (r_running) begin
                    n_loop    = 1'b0;
                    n_elapsed = el_adv;
                    for (int i = 0; i < NUM_CH; i++) begin
                        if (os_hit[i]) begin
                            n_os_done[i] = 1'b1;
                            os_mask[i]   = 1'b1;
                        end
                        if (pd_hit[i]) begin
                            pd_mask[i] = 1'b1;
                            n_cnt[i]   = cnt_inc[i];
                            n_nft[i]   = nft_adv[i];
                        end
                    end
                    if (dur_hit) begin
                        if (i_cfg.loop_en) begin
                            // Wrap: counts are kept, everything else rearms.
                            n_elapsed = '0;
                            n_done    = 1'b0;
                            n_loop    = 1'b1;
                            n_os_done = '0;
                            n_nft     = nft_arm;
                        end else begin
                            n_done    = 1'b1;
                            completed = 1'b1;
                            n_running = 1'b0;
                        end
                    end
                end
            end
            KIND_START, KIND_RESET: begin
                n_elapsed = '0;
                n_running = (i_kind == KIND_START);
                n_done    = 1'b0;
                n_loop    = 1'b0;
                n_os_done = '0;
                n_nft     = nft_arm;
                for (int i = 0; i < NUM_CH; i++) begin
                    n_cnt[i] = '0;
                end
            end
            KIND_STOP: begin
                n_running = 1'b0;
            end
            KIND_RESUME: begin
                if (resume_ok) begin
                    n_running = 1'b1;
                    n_done    = 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign el_out = t_cmp'(n_elapsed);
    assign rem    = dur_cmp - el_out;

    always_comb begin
        o_res.active        = n_running;
        o_res.finished      = n_done;
        o_res.looped        = n_loop;
        o_res.completed     = completed;
        o_res.oneshot_fired = os_mask;
        o_res.period_fired  = pd_mask;
        o_res.count_a       = n_cnt[0];
        o_res.count_b       = n_cnt[1];
        o_res.elapsed       = el_out[TIME_W-1:0];
        o_res.remaining     = (dur_cmp > el_out) ? rem[TIME_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_running <= 1'b0;
            r_done    <= 1'b0;
            r_loop    <= 1'b0;
            r_os_done <= '0;
            for (int i = 0; i < NUM_CH; i++) begin
                r_nft[i] <= '0;
                r_cnt[i] <= '0;
            end
        end else if (i_fire) begin
            r_elapsed <= n_elapsed;
            r_running <= n_running;
            r_done    <= n_done;
            r_loop    <= n_loop;
            r_os_done <= n_os_done;
            r_nft     <= n_nft;
            r_cnt     <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> src/scaled_interval_timer.sv
// A result moves from the input register into the result register and waits
// there until taken. One item per cycle unless the output stalls; the timer
// state is updated as an item moves from the input register into the result
// register, so the next item sees it.
// A stalled result register holds one item while the input register takes one.
// Reset (synchronous, active low) restores register defaults and clears state.
// ----------------------------------------------------------------------------
// scaled_interval_timer
// Fixed-point interval timer with one-shot and periodic compare channels.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_interval_timer #(
    parameter int TIME_BITS       = sit_pkg::TIME_BITS_DEF,
    parameter int SCALE_FRAC_BITS = sit_pkg::SCALE_FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // delta [19:0], zero padding [23:20]
    input  wire logic [sit_pkg::IN_DATA_W-1:0]   s_tdata,
    // kind [2:0]
    input  wire logic [sit_pkg::KIND_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // active [0], finished [1], looped [2], completed [3], oneshot_fired [5:4],
    // period_fired [7:6], period_count_a [23:8], period_count_b [39:24],
    // elapsed [71:40], remaining [103:72]
    output logic [sit_pkg::OUT_W-1:0]            m_tdata,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [sit_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sit_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sit_pkg::*;

    t_cfg               cfg;
    t_result            res;
    logic               in_adv;
    logic               r_in_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [DELTA_W-1:0] r_delta;
    logic               r_out_valid;
    t_result            r_out_data;

    assign o_cfg_ready = 1'b1;

    sit_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // The held item moves on whenever the result register is free or drains.
    assign in_adv   = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_kind  <= s_tuser;
            r_delta <= s_tdata[DELTA_W-1:0];
        end
    end

    sit_core #(
        .TIME_BITS       (TIME_BITS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (in_adv),
        .i_kind  (t_kind'(r_kind)),
        .i_delta (r_delta),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_tready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_out_data <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

endmodule

`default_nettype wire

>>> src/sit_checker.sv
// ----------------------------------------------------------------------------
// sit_checker
// Port-level assertions for the scaled interval timer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sit_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_tready,
    input  wire logic                        m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic [sit_pkg::OUT_W-1:0]   m_tdata
);
    import sit_pkg::*;

    t_result res;

    assign res = m_tdata;

    `SIT_ASSERT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
    `SIT_ASSERT_NR(a_rst_empty, i_clk, !i_rst_n |=> !m_tvalid && s_tready, "pipeline not empty after reset")
    `SIT_ASSERT(a_complete_stop, i_clk, i_rst_n, m_tvalid && res.completed |-> res.finished && !res.active, "completion without a stopped finished timer")
    `SIT_ASSERT(a_done_xor_loop, i_clk, i_rst_n, m_tvalid |-> !(res.finished && res.looped), "finished and looped both set")

endmodule

bind scaled_interval_timer sit_checker u_sit_checker (.*);

`default_nettype wire
